>>> hdl/hsma_pkg.sv
`timescale 1ns / 1ps
package hsma_pkg;

   localparam int MaxSpheres = 256;
   localparam int IdxW = $clog2(MaxSpheres);
   localparam int CntW = $clog2(MaxSpheres + 1);
   localparam int PosW = 24;
   localparam int StepW = 17;
   localparam int DiffW = 26;
   localparam int SqW = 52;
   localparam int SumW = 54;
   localparam logic [SumW-1:0] OneSquared = SumW'(64'h1_0000_0000);

   localparam logic [0:0] CsrBoxLength = 1'b0;
   localparam logic [0:0] CsrSphereCount = 1'b1;

   localparam logic OpLoad = 1'b0;
   localparam logic OpMove = 1'b1;

   typedef struct packed {
      logic [PosW-1:0] x;
      logic [PosW-1:0] y;
      logic [PosW-1:0] z;
   } pos_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic read_self;
      logic make_trial;
      logic read_other;
      logic square;
      logic sum;
      logic test;
      logic write_load;
      logic write_trial;
      logic [IdxW-1:0] addr;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
   } dp_stat_type;

endpackage

>>> hdl/hsma_datapath.sv
`timescale 1ns / 1ps
module hsma_datapath
   import hsma_pkg::*;
(
   input  logic                    clock,
   input  dp_cmd_type              cmd,
   input  logic [PosW-1:0]         box_length,
   input  logic [IdxW-1:0]         req_sphere_index,
   input  logic [PosW-1:0]         req_load_x,
   input  logic [PosW-1:0]         req_load_y,
   input  logic [PosW-1:0]         req_load_z,
   input  logic signed [StepW-1:0] req_step_x,
   input  logic signed [StepW-1:0] req_step_y,
   input  logic signed [StepW-1:0] req_step_z,
   output dp_stat_type             stat,
   output pos_type                 trial,
   output pos_type                 self_pos,
   output pos_type                 load_pos
);

   pos_type mem [MaxSpheres];
   pos_type rd_ff;
   pos_type load_ff;
   pos_type trial_ff;
   pos_type self_ff;
   logic signed [StepW-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [DiffW-1:0] dx_ff, dy_ff, dz_ff;
   logic [SqW-1:0] qx_ff, qy_ff, qz_ff;
   logic hit_ff;

   pos_type trial_in;
   logic signed [DiffW-1:0] dx_in, dy_in, dz_in;

   function automatic logic [PosW-1:0] wrap_axis(
      input logic [PosW-1:0] p, input logic signed [StepW-1:0] s,
      input logic [PosW-1:0] len);
      logic signed [DiffW-1:0] t;
      logic signed [DiffW-1:0] l;
      l = DiffW'($signed({1'b0, len}));
      t = DiffW'($signed({1'b0, p})) + DiffW'(s);
      if (t > l) t = t - l;
      else if (t < 0) t = t + l;
      if (t < 0) t = '0;
      if (t > DiffW'(26'hFF_FFFF)) t = DiffW'(26'hFF_FFFF);
      return t[PosW-1:0];
   endfunction

   function automatic logic signed [DiffW-1:0] image_diff(
      input logic [PosW-1:0] tr, input logic [PosW-1:0] ot,
      input logic [PosW-1:0] len);
      logic signed [DiffW-1:0] d;
      logic signed [DiffW-1:0] l;
      l = DiffW'($signed({1'b0, len}));
      d = DiffW'($signed({1'b0, ot})) - DiffW'($signed({1'b0, tr}));
      if ((d <<< 1) > l) d = d - l;
      else if ((d <<< 1) < -l) d = d + l;
      return d;
   endfunction

   assign trial_in.x = wrap_axis(rd_ff.x, sx_ff, box_length);
   assign trial_in.y = wrap_axis(rd_ff.y, sy_ff, box_length);
   assign trial_in.z = wrap_axis(rd_ff.z, sz_ff, box_length);
   assign dx_in = image_diff(trial_ff.x, rd_ff.x, box_length);
   assign dy_in = image_diff(trial_ff.y, rd_ff.y, box_length);
   assign dz_in = image_diff(trial_ff.z, rd_ff.z, box_length);

   always_ff @(posedge clock) begin
      if (cmd.write_load) begin
         mem[cmd.addr] <= load_ff;
      end else if (cmd.write_trial) begin
         mem[cmd.addr] <= trial_ff;
      end
      rd_ff <= mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         load_ff <= '{x: req_load_x, y: req_load_y, z: req_load_z};
         sx_ff   <= req_step_x;
         sy_ff   <= req_step_y;
         sz_ff   <= req_step_z;
      end
      if (cmd.make_trial) begin
         trial_ff <= trial_in;
         self_ff  <= rd_ff;
      end
      if (cmd.square) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
      if (cmd.sum) begin
         qx_ff <= SqW'(SqW'(dx_ff) * SqW'(dx_ff));
         qy_ff <= SqW'(SqW'(dy_ff) * SqW'(dy_ff));
         qz_ff <= SqW'(SqW'(dz_ff) * SqW'(dz_ff));
      end
      hit_ff <= cmd.test &&
         ((SumW'(qx_ff) + SumW'(qy_ff) + SumW'(qz_ff)) < OneSquared);
   end

   assign stat.hit = hit_ff;
   assign trial = trial_ff;
   assign self_pos = self_ff;
   assign load_pos = load_ff;

   // read_self/read_other are not used by the datapath; addr alone selects the row
   logic unused_ok;
   assign unused_ok = cmd.read_self ^ cmd.read_other ^ req_sphere_index[0];

endmodule

>>> hdl/hsma_control.sv
`timescale 1ns / 1ps
module hsma_control
   import hsma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [IdxW-1:0]   req_sphere_index,
   input  logic [CntW-1:0]   sphere_count,
   input  dp_stat_type       stat,
   input  pos_type           trial,
   input  pos_type           self_pos,
   input  pos_type           load_pos,
   output dp_cmd_type        cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IdxW-1:0]   rsp_result_index,
   output logic              rsp_accepted,
   output logic [PosW-1:0]   rsp_pos_x,
   output logic [PosW-1:0]   rsp_pos_y,
   output logic [PosW-1:0]   rsp_pos_z,
   output logic [31:0]       rsp_moves_tried,
   output logic [31:0]       rsp_moves_taken
);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_TRIAL, S_SCAN, S_DRAIN, S_DONE, S_OUT
   } state_type;

   state_type state_ff;
   logic op_ff;
   logic [IdxW-1:0] idx_ff;
   logic [CntW-1:0] active_ff;
   logic [CntW-1:0] rd_cnt_ff;      // next sphere index to read
   logic [4:0] v_ff;                // valid per pipeline stage of the check
   logic hit_seen_ff;
   logic [31:0] tried_ff, taken_ff;
   logic rsp_valid_ff;
   logic acc_ff;
   pos_type pos_ff;

   logic issue;
   logic [CntW-1:0] cnt_lim;

   assign cnt_lim = (sphere_count > CntW'(MaxSpheres)) ? CntW'(MaxSpheres) : sphere_count;
   assign issue = (state_ff == S_SCAN) && (rd_cnt_ff < active_ff);

   always_comb begin
      cmd = '0;
      cmd.addr = req_sphere_index;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_READ: begin
            cmd.read_self = 1'b1;
            cmd.addr = idx_ff;
            cmd.write_load = (op_ff == OpLoad);
         end
         S_TRIAL: begin
            cmd.make_trial = 1'b1;
            cmd.addr = idx_ff;
         end
         S_SCAN, S_DRAIN: begin
            cmd.read_other = issue;
            cmd.addr = rd_cnt_ff[IdxW-1:0];
            cmd.square = v_ff[0];
            cmd.sum = v_ff[1];
            cmd.test = v_ff[2];
         end
         S_DONE: begin
            cmd.addr = idx_ff;
            cmd.write_trial = !hit_seen_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tried_ff <= '0;
         taken_ff <= '0;
         rsp_valid_ff <= 1'b0;
         v_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_opcode;
                  idx_ff <= req_sphere_index;
                  active_ff <= cnt_lim;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (op_ff == OpLoad) begin
                  acc_ff <= 1'b1;
                  pos_ff <= load_pos;
                  state_ff <= S_OUT;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  tried_ff <= tried_ff + 32'd1;
                  state_ff <= S_TRIAL;
               end
            end
            S_TRIAL: begin
               rd_cnt_ff <= '0;
               v_ff <= '0;
               hit_seen_ff <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_SCAN, S_DRAIN: begin
               // stages: read, diff, square, sum-compare
               v_ff <= {v_ff[3:0],
                  issue && (rd_cnt_ff[IdxW-1:0] != idx_ff)};
               if (issue) rd_cnt_ff <= rd_cnt_ff + CntW'(1);
               if (v_ff[3] && stat.hit) hit_seen_ff <= 1'b1;
               if (state_ff == S_SCAN && !issue) state_ff <= S_DRAIN;
               if (state_ff == S_DRAIN && v_ff[3:0] == '0) state_ff <= S_DONE;
            end
            S_DONE: begin
               acc_ff <= !hit_seen_ff;
               if (!hit_seen_ff) taken_ff <= taken_ff + 32'd1;
               pos_ff <= hit_seen_ff ? self_pos : trial;
               state_ff <= S_OUT;
               rsp_valid_ff <= 1'b1;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_index = idx_ff;
   assign rsp_accepted = acc_ff;
   // rejected move reports the stored position the trial was made from
   assign rsp_pos_x = pos_ff.x;
   assign rsp_pos_y = pos_ff.y;
   assign rsp_pos_z = pos_ff.z;
   assign rsp_moves_tried = tried_ff;
   assign rsp_moves_taken = taken_ff;

endmodule

>>> hdl/hard_sphere_move_acceptor.sv
`timescale 1ns / 1ps
// channel  valid/ready          payload
// req      req_valid/req_ready  opcode, sphere_index, load_x/y/z, step_x/y/z
// rsp      rsp_valid/rsp_ready  result_index, accepted, pos_x/y/z, moves_tried/taken
// csr      csr_write            csr_index, csr_data
// a load writes the sphere and returns its position; a move runs an overlap scan
// that reads one sphere per cycle from memory.
// one item at a time: the next item is taken once the result is taken.
// reset is synchronous; sphere positions are unknown until loaded.
module hard_sphere_move_acceptor
   import hsma_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [7:0]              req_sphere_index,
   input  logic [23:0]             req_load_x,
   input  logic [23:0]             req_load_y,
   input  logic [23:0]             req_load_z,
   input  logic signed [16:0]      req_step_x,
   input  logic signed [16:0]      req_step_y,
   input  logic signed [16:0]      req_step_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_result_index,
   output logic                    rsp_accepted,
   output logic [23:0]             rsp_pos_x,
   output logic [23:0]             rsp_pos_y,
   output logic [23:0]             rsp_pos_z,
   output logic [31:0]             rsp_moves_tried,
   output logic [31:0]             rsp_moves_taken,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [23:0]             csr_data
);

   logic [PosW-1:0] box_ff;
   logic [CntW-1:0] count_ff;
   dp_cmd_type cmd;
   dp_stat_type stat;
   pos_type trial, self_pos, load_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= 24'd655360;
         count_ff <= CntW'(256);
      end else if (csr_write) begin
         case (csr_index)
            CsrBoxLength: box_ff <= csr_data;
            CsrSphereCount: count_ff <= csr_data[CntW-1:0];
            default: ;
         endcase
      end
   end

   hsma_datapath u_dp (
      .clock, .cmd, .box_length(box_ff), .req_sphere_index,
      .req_load_x, .req_load_y, .req_load_z,
      .req_step_x, .req_step_y, .req_step_z,
      .stat, .trial, .self_pos, .load_pos
   );

   hsma_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_sphere_index,
      .sphere_count(count_ff), .stat, .trial, .self_pos, .load_pos, .cmd,
      .rsp_valid, .rsp_ready, .rsp_result_index, .rsp_accepted,
      .rsp_pos_x, .rsp_pos_y, .rsp_pos_z, .rsp_moves_tried, .rsp_moves_taken
   );

endmodule
